// File: hdl/transfer_phase_deadline_watchdog_top_assert.svh
// Assertion macros for the transfer phase deadline watchdog.
// Used by the port checker; needs nothing else.
`ifndef TRANSFER_PHASE_DEADLINE_WATCHDOG_TOP_ASSERT_SVH
`define TRANSFER_PHASE_DEADLINE_WATCHDOG_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define TPDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpdw: implication check failed");

// next-cycle implication, off during reset
`define TPDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpdw: next-cycle check failed");

// behavior right after a reset cycle
`define TPDW_ASSERT_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("tpdw: reset check failed");

`endif

// File: hdl/tpdw_pkg.sv
// Package for the transfer phase deadline watchdog: widths, codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package tpdw_pkg;

  localparam int TIME_BITS_DEFAULT = 40;

  localparam int CMD_W     = 4;
  localparam int NOW_W     = 40;
  localparam int VAL_W     = 40;
  localparam int VERDICT_W = 3;
  localparam int STATUS_W  = 10;
  localparam int BUDGET_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [BUDGET_W-1:0] LARGE_UPLOAD    = 32'd65536;
  localparam logic [STATUS_W-1:0] STATUS_BODY_MIN = 10'd200;
  localparam logic [STATUS_W-1:0] STATUS_MAX      = 10'd1023;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN_REQ   = 4'd0,
    CMD_BEGIN_ROUTE = 4'd1,
    CMD_UPLOAD      = 4'd2,
    CMD_STATUS      = 4'd3,
    CMD_HDR_END     = 4'd4,
    CMD_BODY        = 4'd5,
    CMD_DEADLINE    = 4'd6,
    CMD_CHECK       = 4'd7,
    CMD_CANCEL      = 4'd8
  } cmd_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_RUNNING      = 3'd0,
    VERDICT_DEADLINE     = 3'd1,
    VERDICT_UPLOAD_STALL = 3'd2,
    VERDICT_BODY_STALL   = 3'd3,
    VERDICT_CANCELLED    = 3'd4
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL      = 3'd0,
    CFG_ANSWER     = 3'd1,
    CFG_BODY_TOTAL = 3'd2,
    CFG_IDLE       = 3'd3,
    CFG_UPLOAD_LEN = 3'd4
  } cfg_idx_t;

endpackage

// File: hdl/tpdw_if.sv
// Channel interfaces for the watchdog: event input, verdict output, config write.
// Depends on tpdw_pkg.
`timescale 1ns / 1ps

interface tpdw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tpdw_pkg::CMD_W-1:0]   command;
  logic [tpdw_pkg::NOW_W-1:0]   now_ms;
  logic [tpdw_pkg::VAL_W-1:0]   value;

  modport source (output valid, command, now_ms, value, input ready);
  modport sink   (input valid, command, now_ms, value, output ready);
endinterface

interface tpdw_out_if;
  logic                            valid;
  logic                            ready;
  logic [tpdw_pkg::VERDICT_W-1:0]  verdict;
  logic                            uploading;
  logic                            in_body;
  logic [tpdw_pkg::STATUS_W-1:0]   status_code;

  modport source (output valid, verdict, uploading, in_body, status_code, input ready);
  modport sink   (input valid, verdict, uploading, in_body, status_code, output ready);
endinterface

interface tpdw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tpdw_pkg::CFG_IDX_W-1:0]   index;
  logic [tpdw_pkg::BUDGET_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/transfer_phase_deadline_watchdog_top.sv
// A word accepted on in_ch moves from the event register to the output register on out_ch.
// One event word per cycle unless out_ch stalls; the event register, state update and
// verdict compare form one registered pass, the result sits in an output register.
// Config writes go into registers, and the effective answer budget is registered from them.
// Reset (rst_n low, synchronous) clears config, all transfer state and both valids.
`timescale 1ns / 1ps

module transfer_phase_deadline_watchdog_top #(
  parameter int TIME_BITS = tpdw_pkg::TIME_BITS_DEFAULT
) (
  input logic           clk,
  input logic           rst_n,
  tpdw_in_if.sink       in_ch,
  tpdw_out_if.source    out_ch,
  tpdw_cfg_if.sink      cfg_ch
);

  localparam int CW  = TIME_BITS + 2;
  localparam int BW  = tpdw_pkg::BUDGET_W;
  localparam int VW  = tpdw_pkg::VAL_W;
  localparam int SW  = tpdw_pkg::STATUS_W;

  // config
  logic [BW-1:0] total_r, answer_r, body_total_r, idle_r, upload_len_r;
  logic [BW:0]   answer_eff_r;

  // event register
  logic                       s1_valid_r;
  logic [tpdw_pkg::CMD_W-1:0] s1_cmd_r;
  logic [TIME_BITS-1:0]       s1_now_r;
  logic [VW-1:0]              s1_val_r;

  // transfer state
  logic [TIME_BITS-1:0] start_time_r, start_time_nxt;
  logic                 up_done_r, up_done_nxt;
  logic [TIME_BITS-1:0] up_done_time_r, up_done_time_nxt;
  logic [TIME_BITS-1:0] last_up_time_r, last_up_time_nxt;
  logic [VW-1:0]        up_bytes_r, up_bytes_nxt;
  logic                 body_r, body_nxt;
  logic [TIME_BITS-1:0] body_start_r, body_start_nxt;
  logic [TIME_BITS-1:0] last_body_r, last_body_nxt;
  logic [SW-1:0]        status_r, status_nxt;
  logic                 dl_set_r, dl_set_nxt;
  logic [TIME_BITS-1:0] dl_time_r, dl_time_nxt;
  logic                 cancel_r, cancel_nxt;

  // output register
  logic                           out_valid_r;
  logic [tpdw_pkg::VERDICT_W-1:0] verdict_r;
  logic                           uploading_r;
  logic                           in_body_r;
  logic [SW-1:0]                  status_out_r;

  logic                           s1_take, step, in_fire;
  logic [63:0]                    in_now_w, s1_val_w;
  logic [TIME_BITS-1:0]           val_t;
  logic                           upload_len_zero;
  logic                           dl_hit, up_stall, body_stall;
  logic [tpdw_pkg::VERDICT_W-1:0] judge, verdict_nxt;
  logic [BW:0]                    answer_eff_nxt;

  function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] since,
                                   input logic [CW-1:0] budget);
    logic [TIME_BITS-1:0] d;
    d = now - since;
    return (now >= since) && ({2'b00, d} >= budget);
  endfunction

  function automatic logic [CW-1:0] ext_b(input logic [BW-1:0] b);
    return {{(CW-BW){1'b0}}, b};
  endfunction

  // handshakes
  assign s1_take      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || s1_take;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign step         = s1_valid_r && s1_take;
  assign cfg_ch.ready = 1'b1;

  assign in_now_w = {{(64-tpdw_pkg::NOW_W){1'b0}}, in_ch.now_ms};
  assign s1_val_w = {{(64-VW){1'b0}}, s1_val_r};
  assign val_t    = s1_val_w[TIME_BITS-1:0];

  // config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      answer_r     <= '0;
      body_total_r <= '0;
      idle_r       <= '0;
      upload_len_r <= '0;
      answer_eff_r <= '0;
    end else begin
      answer_eff_r <= answer_eff_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          tpdw_pkg::CFG_TOTAL:      total_r      <= cfg_ch.data;
          tpdw_pkg::CFG_ANSWER:     answer_r     <= cfg_ch.data;
          tpdw_pkg::CFG_BODY_TOTAL: body_total_r <= cfg_ch.data;
          tpdw_pkg::CFG_IDLE:       idle_r       <= cfg_ch.data;
          tpdw_pkg::CFG_UPLOAD_LEN: upload_len_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // answer budget, extended by idle budget for large uploads
  always_comb begin
    if ((answer_r != '0) && (idle_r != '0) && (upload_len_r >= tpdw_pkg::LARGE_UPLOAD)) begin
      answer_eff_nxt = {1'b0, answer_r} + {1'b0, idle_r};
    end else begin
      answer_eff_nxt = {1'b0, answer_r};
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_ch.command;
      s1_now_r <= in_now_w[TIME_BITS-1:0];
      s1_val_r <= in_ch.value;
    end
  end

  // verdict from state before the update
  always_comb begin
    dl_hit = ((total_r != '0) && elapsed(s1_now_r, start_time_r, ext_b(total_r))) ||
             (up_done_r && !body_r && (answer_eff_r != '0) &&
              elapsed(s1_now_r, up_done_time_r, {{(CW-BW-1){1'b0}}, answer_eff_r})) ||
             (!up_done_r && (body_total_r != '0) &&
              elapsed(s1_now_r, start_time_r, ext_b(body_total_r))) ||
             (body_r && (body_total_r != '0) &&
              elapsed(s1_now_r, body_start_r, ext_b(body_total_r))) ||
             (dl_set_r && (s1_now_r >= dl_time_r));
    up_stall   = !up_done_r && (idle_r != '0) &&
                 elapsed(s1_now_r, last_up_time_r, ext_b(idle_r));
    body_stall = body_r && (idle_r != '0) &&
                 elapsed(s1_now_r, last_body_r, ext_b(idle_r));
    if (cancel_r) begin
      judge = tpdw_pkg::VERDICT_CANCELLED;
    end else if (dl_hit) begin
      judge = tpdw_pkg::VERDICT_DEADLINE;
    end else if (up_stall) begin
      judge = tpdw_pkg::VERDICT_UPLOAD_STALL;
    end else if (body_stall) begin
      judge = tpdw_pkg::VERDICT_BODY_STALL;
    end else begin
      judge = tpdw_pkg::VERDICT_RUNNING;
    end
  end

  assign upload_len_zero = (upload_len_r == '0);

  // state update
  always_comb begin
    start_time_nxt   = start_time_r;
    up_done_nxt      = up_done_r;
    up_done_time_nxt = up_done_time_r;
    last_up_time_nxt = last_up_time_r;
    up_bytes_nxt     = up_bytes_r;
    body_nxt         = body_r;
    body_start_nxt   = body_start_r;
    last_body_nxt    = last_body_r;
    status_nxt       = status_r;
    dl_set_nxt       = dl_set_r;
    dl_time_nxt      = dl_time_r;
    cancel_nxt       = cancel_r;
    verdict_nxt      = tpdw_pkg::VERDICT_RUNNING;
    case (s1_cmd_r)
      tpdw_pkg::CMD_BEGIN_REQ: begin
        start_time_nxt   = s1_now_r;
        last_up_time_nxt = s1_now_r;
        up_done_nxt      = upload_len_zero;
        up_done_time_nxt = upload_len_zero ? s1_now_r : '0;
        up_bytes_nxt     = '0;
        body_nxt         = 1'b0;
        body_start_nxt   = '0;
        last_body_nxt    = '0;
        status_nxt       = '0;
        dl_set_nxt       = 1'b0;
        dl_time_nxt      = '0;
        cancel_nxt       = 1'b0;
      end
      tpdw_pkg::CMD_BEGIN_ROUTE: begin
        up_bytes_nxt     = '0;
        last_up_time_nxt = s1_now_r;
        up_done_nxt      = upload_len_zero;
        up_done_time_nxt = upload_len_zero ? s1_now_r : '0;
      end
      tpdw_pkg::CMD_UPLOAD: begin
        if (s1_val_r > up_bytes_r) begin
          up_bytes_nxt     = s1_val_r;
          last_up_time_nxt = s1_now_r;
        end
        if (!up_done_r && (s1_val_r >= {{(VW-BW){1'b0}}, upload_len_r})) begin
          up_done_nxt      = 1'b1;
          up_done_time_nxt = s1_now_r;
        end
      end
      tpdw_pkg::CMD_STATUS: begin
        status_nxt = (s1_val_r > {{(VW-SW){1'b0}}, tpdw_pkg::STATUS_MAX}) ?
                     tpdw_pkg::STATUS_MAX : s1_val_r[SW-1:0];
        if (!up_done_r) begin
          up_done_nxt      = 1'b1;
          up_done_time_nxt = s1_now_r;
        end
        body_nxt = 1'b0;
      end
      tpdw_pkg::CMD_HDR_END: begin
        if (status_r >= tpdw_pkg::STATUS_BODY_MIN) begin
          body_nxt       = 1'b1;
          body_start_nxt = s1_now_r;
          last_body_nxt  = s1_now_r;
        end
      end
      tpdw_pkg::CMD_BODY: begin
        last_body_nxt = s1_now_r;
      end
      tpdw_pkg::CMD_DEADLINE: begin
        dl_set_nxt  = 1'b1;
        dl_time_nxt = val_t;
      end
      tpdw_pkg::CMD_CHECK: begin
        verdict_nxt = judge;
      end
      tpdw_pkg::CMD_CANCEL: begin
        cancel_nxt  = 1'b1;
        verdict_nxt = tpdw_pkg::VERDICT_CANCELLED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r   <= '0;
      up_done_r      <= 1'b0;
      up_done_time_r <= '0;
      last_up_time_r <= '0;
      up_bytes_r     <= '0;
      body_r         <= 1'b0;
      body_start_r   <= '0;
      last_body_r    <= '0;
      status_r       <= '0;
      dl_set_r       <= 1'b0;
      dl_time_r      <= '0;
      cancel_r       <= 1'b0;
    end else if (step) begin
      start_time_r   <= start_time_nxt;
      up_done_r      <= up_done_nxt;
      up_done_time_r <= up_done_time_nxt;
      last_up_time_r <= last_up_time_nxt;
      up_bytes_r     <= up_bytes_nxt;
      body_r         <= body_nxt;
      body_start_r   <= body_start_nxt;
      last_body_r    <= last_body_nxt;
      status_r       <= status_nxt;
      dl_set_r       <= dl_set_nxt;
      dl_time_r      <= dl_time_nxt;
      cancel_r       <= cancel_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      verdict_r    <= verdict_nxt;
      uploading_r  <= !up_done_nxt;
      in_body_r    <= body_nxt;
      status_out_r <= status_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.uploading   = uploading_r;
  assign out_ch.in_body     = in_body_r;
  assign out_ch.status_code = status_out_r;

endmodule

// File: hdl/tpdw_check.sv
// Port-level checker for the watchdog result channel, bound to the top level.
// Depends on tpdw_pkg and transfer_phase_deadline_watchdog_top_assert.svh.
`timescale 1ns / 1ps
`include "transfer_phase_deadline_watchdog_top_assert.svh"

module tpdw_check (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tpdw_pkg::VERDICT_W-1:0] out_verdict,
  input logic                           out_uploading,
  input logic                           out_in_body,
  input logic [tpdw_pkg::STATUS_W-1:0]  out_status_code
);

  // body phase only opens on a status of 200 or more
  `TPDW_ASSERT_IMP(a_body_needs_ok, clk, rst_n, out_valid && out_in_body, out_status_code >= tpdw_pkg::STATUS_BODY_MIN)
  `TPDW_ASSERT_IMP(a_up_stall_uploading, clk, rst_n, out_valid && (out_verdict == tpdw_pkg::VERDICT_UPLOAD_STALL), out_uploading)
  `TPDW_ASSERT_IMP(a_body_stall_in_body, clk, rst_n, out_valid && (out_verdict == tpdw_pkg::VERDICT_BODY_STALL), out_in_body)
  `TPDW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_verdict) && $stable(out_status_code))
  `TPDW_ASSERT_RST(a_reset_empty, clk, rst_n, !out_valid)

endmodule

bind transfer_phase_deadline_watchdog_top tpdw_check u_tpdw_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_verdict     (out_ch.verdict),
  .out_uploading   (out_ch.uploading),
  .out_in_body     (out_ch.in_body),
  .out_status_code (out_ch.status_code)
);

// File: tb/tb_top.sv
// Self-checking bench for transfer_phase_deadline_watchdog_top: a directed table, then random
// transfers under several budget settings and handshake idle patterns.
// Depends on tpdw_pkg and the channel interfaces in tpdw_if.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN_PAD  = 4;
  localparam int WORDS_PER_PHASE = 84;
  localparam int NUM_PHASES = 8;
  localparam logic [tpdw_pkg::CMD_W-1:0]    CMD_NONE_HI = 4'd15;
  localparam logic [tpdw_pkg::NOW_W-1:0]    TIME_TOP    = '1;
  localparam logic [tpdw_pkg::VAL_W-1:0]    VAL_TOP     = '1;
  localparam logic [tpdw_pkg::BUDGET_W-1:0] BUDGET_TOP  = '1;

  typedef struct packed {
    tpdw_pkg::verdict_t             verdict;
    logic                           uploading;
    logic                           in_body;
    logic [tpdw_pkg::STATUS_W-1:0]  status;
  } watch_res_t;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    tpdw_pkg::cfg_idx_t           reg_idx;
    logic [tpdw_pkg::CMD_W-1:0]   cmd;
    logic [tpdw_pkg::NOW_W-1:0]   now_ms;
    logic [tpdw_pkg::VAL_W-1:0]   value;
    bit                           typed;
    watch_res_t                   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tpdw_in_if  in_ch();
  tpdw_out_if out_ch();
  tpdw_cfg_if cfg_ch();

  transfer_phase_deadline_watchdog_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // budget registers as the block should hold them
  logic [tpdw_pkg::BUDGET_W-1:0] cfg_total, cfg_answer, cfg_body_total, cfg_idle, cfg_upl_len;

  // transfer state of the watchdog
  logic [tpdw_pkg::NOW_W-1:0]    sess_start, upl_done_at, upl_last_at, body_start_at;
  logic [tpdw_pkg::NOW_W-1:0]    body_last_at;
  logic [tpdw_pkg::VAL_W-1:0]    upl_bytes;
  logic [tpdw_pkg::NOW_W-1:0]    dl_at;
  logic [tpdw_pkg::STATUS_W-1:0] status_q;
  logic                          upl_done, body_on, dl_armed, cancel_seen;

  watch_res_t verdict_q[$];
  stim_row_t  directed_rows[$];

  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int results_seen = 0;
  int settings_done = 0;
  int verdict_tally[5];
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int pace_ms = 10;

  function automatic logic [tpdw_pkg::VAL_W-1:0] widen(logic [31:0] x);
    return {{(tpdw_pkg::VAL_W-32){1'b0}}, x};
  endfunction

  function automatic void clear_watch();
    sess_start = '0; upl_done_at = '0; upl_last_at = '0; upl_bytes = '0;
    body_start_at = '0; body_last_at = '0; dl_at = '0; status_q = '0;
    upl_done = 1'b0; body_on = 1'b0; dl_armed = 1'b0; cancel_seen = 1'b0;
  endfunction

  function automatic void restart_upload(logic [tpdw_pkg::NOW_W-1:0] now);
    upl_last_at = now;
    upl_done    = (cfg_upl_len == '0);
    upl_done_at = upl_done ? now : '0;
  endfunction

  // backwards time never counts as elapsed
  function automatic bit span_reached(logic [tpdw_pkg::NOW_W-1:0] now,
                                      logic [tpdw_pkg::NOW_W-1:0] since,
                                      logic [63:0] budget);
    if (now < since) return 1'b0;
    return 64'(now - since) >= budget;
  endfunction

  function automatic watch_res_t step_watch(logic [tpdw_pkg::CMD_W-1:0] cmd,
                                            logic [tpdw_pkg::NOW_W-1:0] now,
                                            logic [tpdw_pkg::VAL_W-1:0] val);
    watch_res_t r;
    logic [63:0] answer;
    tpdw_pkg::verdict_t v;
    v = tpdw_pkg::VERDICT_RUNNING;
    case (cmd)
      tpdw_pkg::CMD_BEGIN_REQ: begin
        clear_watch();
        sess_start = now;
        restart_upload(now);
      end
      tpdw_pkg::CMD_BEGIN_ROUTE: begin
        upl_bytes = '0;
        restart_upload(now);
      end
      tpdw_pkg::CMD_UPLOAD: begin
        if (val > upl_bytes) begin
          upl_bytes   = val;
          upl_last_at = now;
        end
        if (!upl_done && val >= widen(cfg_upl_len)) begin
          upl_done    = 1'b1;
          upl_done_at = now;
        end
      end
      tpdw_pkg::CMD_STATUS: begin
        status_q = (val > widen(32'(tpdw_pkg::STATUS_MAX))) ? tpdw_pkg::STATUS_MAX :
                   val[tpdw_pkg::STATUS_W-1:0];
        if (!upl_done) begin
          upl_done    = 1'b1;
          upl_done_at = now;
        end
        body_on = 1'b0;
      end
      tpdw_pkg::CMD_HDR_END: begin
        if (status_q >= tpdw_pkg::STATUS_BODY_MIN) begin
          body_on       = 1'b1;
          body_start_at = now;
          body_last_at  = now;
        end
      end
      tpdw_pkg::CMD_BODY: body_last_at = now;
      tpdw_pkg::CMD_DEADLINE: begin
        dl_armed = 1'b1;
        dl_at    = val;
      end
      tpdw_pkg::CMD_CHECK: begin
        answer = 64'(cfg_answer);
        if (cfg_answer != '0 && cfg_idle != '0 && cfg_upl_len >= tpdw_pkg::LARGE_UPLOAD)
          answer = answer + 64'(cfg_idle);
        if (cancel_seen)
          v = tpdw_pkg::VERDICT_CANCELLED;
        else if ((cfg_total != '0 && span_reached(now, sess_start, 64'(cfg_total))) ||
                 (upl_done && !body_on && answer != '0 &&
                  span_reached(now, upl_done_at, answer)) ||
                 (!upl_done && cfg_body_total != '0 &&
                  span_reached(now, sess_start, 64'(cfg_body_total))) ||
                 (body_on && cfg_body_total != '0 &&
                  span_reached(now, body_start_at, 64'(cfg_body_total))) ||
                 (dl_armed && now >= dl_at))
          v = tpdw_pkg::VERDICT_DEADLINE;
        else if (!upl_done && cfg_idle != '0 &&
                 span_reached(now, upl_last_at, 64'(cfg_idle)))
          v = tpdw_pkg::VERDICT_UPLOAD_STALL;
        else if (body_on && cfg_idle != '0 &&
                 span_reached(now, body_last_at, 64'(cfg_idle)))
          v = tpdw_pkg::VERDICT_BODY_STALL;
      end
      tpdw_pkg::CMD_CANCEL: begin
        cancel_seen = 1'b1;
        v = tpdw_pkg::VERDICT_CANCELLED;
      end
      default: ;
    endcase
    r.verdict   = v;
    r.uploading = !upl_done;
    r.in_body   = body_on;
    r.status    = status_q;
    return r;
  endfunction

  function automatic logic [tpdw_pkg::VAL_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[tpdw_pkg::VAL_W-1:0];
  endfunction

  function automatic void row_evt(logic [tpdw_pkg::CMD_W-1:0] cmd,
                                  logic [tpdw_pkg::NOW_W-1:0] now,
                                  logic [tpdw_pkg::VAL_W-1:0] val);
    stim_row_t r;
    r.kind = ROW_EVENT; r.reg_idx = tpdw_pkg::CFG_TOTAL; r.cmd = cmd; r.now_ms = now;
    r.value = val; r.typed = 1'b0; r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_typed(logic [tpdw_pkg::CMD_W-1:0] cmd,
                                    logic [tpdw_pkg::NOW_W-1:0] now,
                                    logic [tpdw_pkg::VAL_W-1:0] val, tpdw_pkg::verdict_t v,
                                    logic upl, logic body,
                                    logic [tpdw_pkg::STATUS_W-1:0] st);
    stim_row_t r;
    r.kind = ROW_EVENT; r.reg_idx = tpdw_pkg::CFG_TOTAL; r.cmd = cmd; r.now_ms = now;
    r.value = val; r.typed = 1'b1;
    r.want.verdict = v; r.want.uploading = upl; r.want.in_body = body; r.want.status = st;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_cfg(tpdw_pkg::cfg_idx_t idx, logic [tpdw_pkg::BUDGET_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_CONFIG; r.reg_idx = idx; r.cmd = tpdw_pkg::CMD_CHECK; r.now_ms = '0;
    r.value = widen(data); r.typed = 1'b0; r.want = '0;
    directed_rows.push_back(r);
  endfunction

  // called at a falling edge; returns at a falling edge with valid left as driven
  task automatic drive_word(stim_row_t w);
    watch_res_t p;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= w.cmd;
    in_ch.now_ms  <= w.now_ms;
    in_ch.value   <= w.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = step_watch(w.cmd, w.now_ms, w.value);
    verdict_q.push_back(w.typed ? w.want : p);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_evt(logic [tpdw_pkg::CMD_W-1:0] cmd, logic [tpdw_pkg::NOW_W-1:0] now,
                          logic [tpdw_pkg::VAL_W-1:0] val);
    stim_row_t r;
    r.kind = ROW_EVENT; r.reg_idx = tpdw_pkg::CFG_TOTAL; r.cmd = cmd; r.now_ms = now;
    r.value = val; r.typed = 1'b0; r.want = '0;
    drive_word(r);
  endtask

  task automatic write_reg(tpdw_pkg::cfg_idx_t idx, logic [tpdw_pkg::BUDGET_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      tpdw_pkg::CFG_TOTAL:      cfg_total      = data;
      tpdw_pkg::CFG_ANSWER:     cfg_answer     = data;
      tpdw_pkg::CFG_BODY_TOTAL: cfg_body_total = data;
      tpdw_pkg::CFG_IDLE:       cfg_idle       = data;
      tpdw_pkg::CFG_UPLOAD_LEN: cfg_upl_len    = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_budgets(logic [tpdw_pkg::BUDGET_W-1:0] total,
                             logic [tpdw_pkg::BUDGET_W-1:0] answer,
                             logic [tpdw_pkg::BUDGET_W-1:0] body,
                             logic [tpdw_pkg::BUDGET_W-1:0] idle,
                             logic [tpdw_pkg::BUDGET_W-1:0] len);
    write_reg(tpdw_pkg::CFG_TOTAL, total);
    write_reg(tpdw_pkg::CFG_ANSWER, answer);
    write_reg(tpdw_pkg::CFG_BODY_TOTAL, body);
    write_reg(tpdw_pkg::CFG_IDLE, idle);
    write_reg(tpdw_pkg::CFG_UPLOAD_LEN, len);
    settings_done++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  function automatic logic [tpdw_pkg::BUDGET_W-1:0] pick_budget();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return BUDGET_TOP;
      default: return $urandom_range(5, 300);
    endcase
  endfunction

  function automatic logic [tpdw_pkg::BUDGET_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return tpdw_pkg::LARGE_UPLOAD;
      2: return BUDGET_TOP;
      3: return $urandom;
      default: return $urandom_range(1, 100000);
    endcase
  endfunction

  function automatic logic [tpdw_pkg::NOW_W-1:0] later(logic [tpdw_pkg::NOW_W-1:0] t);
    case ($urandom_range(0, 19))
      0:       return t - widen($urandom_range(1, pace_ms));
      1, 2, 3: return t + widen($urandom_range(0, 6 * pace_ms));
      default: return t + widen($urandom_range(0, pace_ms));
    endcase
  endfunction

  task automatic maybe_check(logic [tpdw_pkg::NOW_W-1:0] t);
    if ($urandom_range(0, 2) == 0) send_evt(tpdw_pkg::CMD_CHECK, t, rand40());
  endtask

  function automatic logic [tpdw_pkg::VAL_W-1:0] pick_status();
    case ($urandom_range(0, 9))
      6:       return widen($urandom_range(100, 199));
      7:       return widen($urandom_range(300, 599));
      8:       return ($urandom_range(0, 1) != 0) ? rand40() :
                      widen($urandom_range(1024, 70000));
      9:       return widen($urandom_range(0, 1023));
      default: return widen($urandom_range(200, 299));
    endcase
  endfunction

  // one request from start to end of body, with checks sprinkled in
  task automatic random_transfer();
    logic [tpdw_pkg::NOW_W-1:0] t;
    logic [63:0] bytes;
    int n_up, n_body;
    t = ($urandom_range(0, 7) == 0) ? TIME_TOP - widen($urandom_range(0, 200)) : rand40();
    send_evt(tpdw_pkg::CMD_BEGIN_REQ, t, rand40());
    if ($urandom_range(0, 5) == 0) begin
      t = later(t);
      send_evt(tpdw_pkg::CMD_BEGIN_ROUTE, t, rand40());
    end
    if ($urandom_range(0, 3) == 0)
      send_evt(tpdw_pkg::CMD_DEADLINE, t, ($urandom_range(0, 9) == 0) ? rand40() :
                                t + widen($urandom_range(0, 10 * pace_ms)));
    maybe_check(t);
    n_up = $urandom_range(0, 4);
    for (int i = 1; i <= n_up; i++) begin
      t = later(t);
      bytes = (64'(cfg_upl_len) * 64'(i)) / 64'(n_up);
      if ($urandom_range(0, 5) == 0) bytes = 64'(rand40());
      send_evt(tpdw_pkg::CMD_UPLOAD, t, bytes[tpdw_pkg::VAL_W-1:0]);
      maybe_check(t);
    end
    t = later(t);
    maybe_check(t);
    send_evt(tpdw_pkg::CMD_STATUS, t, pick_status());
    maybe_check(later(t));
    t = later(t);
    send_evt(tpdw_pkg::CMD_HDR_END, t, rand40());
    n_body = $urandom_range(0, 5);
    for (int i = 0; i < n_body; i++) begin
      t = later(t);
      send_evt(tpdw_pkg::CMD_BODY, t, rand40());
      maybe_check(t);
    end
    t = later(t);
    if ($urandom_range(0, 7) == 0) begin
      send_evt(tpdw_pkg::CMD_CANCEL, t, rand40());
      t = later(t);
    end
    send_evt(tpdw_pkg::CMD_CHECK, t, rand40());
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_evt(4'($urandom_range(0, 15)), rand40(), rand40());
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

  always @(posedge clk) begin
    watch_res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.verdict <= tpdw_pkg::VERDICT_CANCELLED) verdict_tally[out_ch.verdict]++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected word: verdict %0d uploading %0b in_body %0b status %0d",
                 $time, out_ch.verdict, out_ch.uploading, out_ch.in_body, out_ch.status_code);
        errors++;
      end else begin
        w = verdict_q.pop_front();
        if (out_ch.verdict !== w.verdict) begin
          $display("%0t: verdict mismatch: expected %0d, got %0d", $time, w.verdict,
                   out_ch.verdict);
          errors++;
        end
        if (out_ch.uploading !== w.uploading) begin
          $display("%0t: uploading mismatch: expected %0b, got %0b", $time, w.uploading,
                   out_ch.uploading);
          errors++;
        end
        if (out_ch.in_body !== w.in_body) begin
          $display("%0t: in_body mismatch: expected %0b, got %0b", $time, w.in_body,
                   out_ch.in_body);
          errors++;
        end
        if (out_ch.status_code !== w.status) begin
          $display("%0t: status_code mismatch: expected %0d, got %0d", $time, w.status,
                   out_ch.status_code);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == MAX_CYCLES) begin
      $display("%0t: timeout with %0d words outstanding", $time, verdict_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int directed_words;
    int phase_base;
    in_ch.valid = 1'b0; in_ch.command = '0; in_ch.now_ms = '0; in_ch.value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = tpdw_pkg::CFG_TOTAL; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    cfg_total = '0; cfg_answer = '0; cfg_body_total = '0; cfg_idle = '0; cfg_upl_len = '0;
    clear_watch();
    foreach (verdict_tally[i]) verdict_tally[i] = 0;

    // reset values of every budget are zero
    row_typed(tpdw_pkg::CMD_CHECK, '0, '0, tpdw_pkg::VERDICT_RUNNING, 1'b1, 1'b0, '0);
    row_typed(CMD_NONE_HI, TIME_TOP, VAL_TOP, tpdw_pkg::VERDICT_RUNNING, 1'b1, 1'b0, '0);
    row_typed(tpdw_pkg::CMD_BEGIN_REQ, 40'd100, '0, tpdw_pkg::VERDICT_RUNNING, 1'b0, 1'b0,
              '0);
    row_typed(tpdw_pkg::CMD_STATUS, 40'd101, VAL_TOP, tpdw_pkg::VERDICT_RUNNING, 1'b0, 1'b0,
              tpdw_pkg::STATUS_MAX);
    row_typed(tpdw_pkg::CMD_HDR_END, 40'd102, '0, tpdw_pkg::VERDICT_RUNNING, 1'b0, 1'b1,
              tpdw_pkg::STATUS_MAX);
    row_evt(tpdw_pkg::CMD_BODY, 40'd103, VAL_TOP);
    row_typed(tpdw_pkg::CMD_DEADLINE, 40'd105, '0, tpdw_pkg::VERDICT_RUNNING, 1'b0, 1'b1,
              tpdw_pkg::STATUS_MAX);
    row_typed(tpdw_pkg::CMD_CHECK, 40'd106, '0, tpdw_pkg::VERDICT_DEADLINE, 1'b0, 1'b1,
              tpdw_pkg::STATUS_MAX);
    row_typed(tpdw_pkg::CMD_CANCEL, 40'd107, '0, tpdw_pkg::VERDICT_CANCELLED, 1'b0, 1'b1,
              tpdw_pkg::STATUS_MAX);
    row_typed(tpdw_pkg::CMD_CHECK, 40'd108, '0, tpdw_pkg::VERDICT_CANCELLED, 1'b0, 1'b1,
              tpdw_pkg::STATUS_MAX);
    row_cfg(tpdw_pkg::CFG_TOTAL, 32'd1000);
    row_cfg(tpdw_pkg::CFG_ANSWER, 32'd50);
    row_cfg(tpdw_pkg::CFG_BODY_TOTAL, 32'd300);
    row_cfg(tpdw_pkg::CFG_IDLE, 32'd20);
    row_cfg(tpdw_pkg::CFG_UPLOAD_LEN, tpdw_pkg::LARGE_UPLOAD);
    row_typed(tpdw_pkg::CMD_BEGIN_REQ, 40'd1000, '0, tpdw_pkg::VERDICT_RUNNING, 1'b1, 1'b0,
              '0);
    row_evt(tpdw_pkg::CMD_UPLOAD, 40'd1010, 40'd100);
    row_evt(tpdw_pkg::CMD_CHECK, 40'd1031, '0);
    row_evt(tpdw_pkg::CMD_CHECK, 40'd999, '0);
    row_evt(tpdw_pkg::CMD_UPLOAD, 40'd1040, 40'd65536);
    row_evt(tpdw_pkg::CMD_CHECK, 40'd1100, '0);
    row_evt(tpdw_pkg::CMD_CHECK, 40'd1110, '0);
    row_evt(tpdw_pkg::CMD_STATUS, 40'd1111, 40'd199);
    row_evt(tpdw_pkg::CMD_HDR_END, 40'd1112, '0);
    row_evt(tpdw_pkg::CMD_STATUS, 40'd1113, 40'd200);
    row_evt(tpdw_pkg::CMD_HDR_END, 40'd1114, '0);
    row_evt(tpdw_pkg::CMD_CHECK, 40'd1135, '0);
    row_evt(tpdw_pkg::CMD_BEGIN_ROUTE, 40'd1140, '0);
    row_evt(tpdw_pkg::CMD_CHECK, 40'd3000, '0);
    row_cfg(tpdw_pkg::CFG_TOTAL, BUDGET_TOP);
    row_cfg(tpdw_pkg::CFG_ANSWER, BUDGET_TOP);
    row_cfg(tpdw_pkg::CFG_BODY_TOTAL, BUDGET_TOP);
    row_cfg(tpdw_pkg::CFG_IDLE, BUDGET_TOP);
    row_cfg(tpdw_pkg::CFG_UPLOAD_LEN, BUDGET_TOP);
    row_typed(tpdw_pkg::CMD_BEGIN_REQ, '0, '0, tpdw_pkg::VERDICT_RUNNING, 1'b1, 1'b0, '0);
    row_evt(tpdw_pkg::CMD_UPLOAD, 40'd1, VAL_TOP);
    row_typed(tpdw_pkg::CMD_CHECK, TIME_TOP, '0, tpdw_pkg::VERDICT_DEADLINE, 1'b0, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value[tpdw_pkg::BUDGET_W-1:0]);
      end else begin
        drive_word(directed_rows[i]);
      end
    end
    directed_words = words_sent;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      case (ph)
        0: set_budgets($urandom_range(100, 600), $urandom_range(20, 120),
                       $urandom_range(60, 300), $urandom_range(10, 60), $urandom_range(1, 5000));
        1: set_budgets(BUDGET_TOP, BUDGET_TOP, BUDGET_TOP, BUDGET_TOP, BUDGET_TOP);
        2: set_budgets('0, '0, '0, '0, '0);
        3: set_budgets($urandom_range(100, 600), $urandom_range(20, 120),
                       $urandom_range(60, 300), $urandom_range(10, 60),
                       $urandom_range(tpdw_pkg::LARGE_UPLOAD, 200000));
        default: set_budgets(pick_budget(), pick_budget(), pick_budget(), pick_budget(),
                             pick_len());
      endcase
      pace_ms = $urandom_range(2, 40);
      case (ph % 4)
        1: src_idle_pct = 69;
        2: sink_stall_pct = 69;
        3: begin
          src_idle_pct   = 30;
          sink_stall_pct = 30;
        end
        default: ;
      endcase
      phase_base = words_sent;
      while (words_sent - phase_base < WORDS_PER_PHASE) random_transfer();
    end

    wait_idle();
    $display("Run covered %0d event words (%0d directed), %0d results, %0d budget settings",
             words_sent, directed_words, results_seen, settings_done);
    $display("Verdicts: running %0d, deadline %0d, upload stall %0d, body stall %0d, cancel %0d",
             verdict_tally[tpdw_pkg::VERDICT_RUNNING], verdict_tally[tpdw_pkg::VERDICT_DEADLINE],
             verdict_tally[tpdw_pkg::VERDICT_UPLOAD_STALL],
             verdict_tally[tpdw_pkg::VERDICT_BODY_STALL],
             verdict_tally[tpdw_pkg::VERDICT_CANCELLED]);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
